>>> rtl/lazy_delete_sampling_set_assert.svh
// Assertion macros for the lazy-deletion sampling set.
// Used by the top level only; no other dependencies.
`ifndef LAZY_DELETE_SAMPLING_SET_ASSERT_SVH
`define LAZY_DELETE_SAMPLING_SET_ASSERT_SVH
`ifndef NO_ASSERTIONS
// consequent must hold in the cycle after the antecedent
`define LDSS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ldss: next-cycle check failed");
// consequent must hold in the same cycle as the antecedent
`define LDSS_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ldss: same-cycle check failed");
`else
`define LDSS_ASSERT_NEXT(lbl, ante, cons)
`define LDSS_ASSERT_SAME(lbl, ante, cons)
`endif
`endif

>>> rtl/ldss_pkg.sv
// Shared widths, codes, command/status structs and the xorshift step
// for the lazy-deletion sampling set. No dependencies.
package ldss_pkg;

   localparam int VALUE_W       = 16;
   localparam int VALUE_SPACE   = 1 << VALUE_W;
   localparam int LIST_CAPACITY = 4096;
   localparam int LEN_W         = $clog2(LIST_CAPACITY + 1);
   localparam int IDX_W         = $clog2(LIST_CAPACITY);
   localparam int CMD_W         = 3;
   localparam int STATUS_W      = 3;
   localparam int FLAG_W        = 2;
   localparam int RNG_W         = 32;
   localparam int DIV_CNT_W     = $clog2(RNG_W + 1);
   localparam int RSP_DATA_W    = 32;
   localparam int RSP_USER_W    = 4;

   localparam logic [RNG_W-1:0] RNG_RESET = 32'd1234567;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SIZE     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SAMPLE   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_EXTRACT  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd6;
   localparam logic [CMD_W-1:0] CMD_COMPACT  = 3'd7;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

   // membership flags
   localparam logic [FLAG_W-1:0] FLAG_ABSENT = 2'd0;
   localparam logic [FLAG_W-1:0] FLAG_LIVE   = 2'd1;
   localparam logic [FLAG_W-1:0] FLAG_STALE  = 2'd2;

   typedef struct packed {
      logic accept;
      logic clr_step;
      logic frd_value;
      logic frd_elem;
      logic exec_single;
      logic set_empty;
      logic rng_start;
      logic div_step;
      logic idx_from_rem;
      logic idx_clear;
      logic idx_inc;
      logic lrd_idx;
      logic lrd_last;
      logic cap_elem;
      logic cap_flag;
      logic cap_last;
      logic drop;
      logic set_vout;
      logic flag_clear_elem;
      logic list_clear;
      logic stale_clear;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             sweep_done;
      logic             empty_set;
      logic             div_done;
      logic             idx_at_end;
      logic             stale_zero;
      logic             stale_ok;
      logic             elem_live;
      logic             rsp_free;
   } dp_status_type;

   // one xorshift32 step
   function automatic logic [RNG_W-1:0] xorshift_next(input logic [RNG_W-1:0] x);
      logic [RNG_W-1:0] y;
      y = x ^ (x << 13);
      y = y ^ (y >> 17);
      y = y ^ (y << 5);
      return y;
   endfunction

endpackage

>>> rtl/lazy_delete_sampling_set.sv
// Top level of the lazy-deletion sampling set: sequencer plus datapath.
// Depends on ldss_pkg, ldss_ctrl, ldss_dp and the assertion macro header.
//
// Set over 16-bit values with insert, remove, contains, size, sample,
// extract, clear and compact; remove only marks an entry stale, and
// sample/extract purge stale entries they hit. After reset the block
// clears its 65536-entry flag memory one entry a cycle, so no request is
// taken until that sweep is done (seed writes are taken throughout).
// One request is worked at a time: insert, remove and contains read the
// flag of the value, act on it and then load the response; size goes
// straight to loading its response. Sample and extract draw an index as
// the generator output modulo the list length, found by a bit-serial
// restoring division, then read that entry and its flag; every stale
// entry met costs one more draw. Clear visits every list entry and
// clears its flag; compact visits entries in order, purging stale ones,
// until the end of the list or until no stale entry is left. The next
// request is taken while a response still waits in the output register.
`include "lazy_delete_sampling_set_assert.svh"

module lazy_delete_sampling_set (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ldss_pkg::VALUE_W-1:0]      req_tdata,  // [15:0] value
   input  logic [ldss_pkg::CMD_W-1:0]        req_tuser,  // [2:0] cmd
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ldss_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // [15:0] value_out, [28:16] live_count
   output logic [ldss_pkg::RSP_USER_W-1:0]   rsp_tuser,  // [2:0] status, [3] found
   input  logic                              csr_wr_en,
   input  logic [ldss_pkg::RNG_W-1:0]        csr_wr_data
);

   ldss_pkg::ctrl_cmd_type  ctl;
   ldss_pkg::dp_status_type sts;

   ldss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .sts        (sts),
      .req_tready (req_tready),
      .ctl        (ctl)
   );

   ldss_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tready  (rsp_tready),
      .ctl         (ctl),
      .sts         (sts),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   // busy after taking a request, counts consistent, response follows load
   `LDSS_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   `LDSS_ASSERT_SAME(a_stale_within_list, 1'b1, sts.stale_ok)
   `LDSS_ASSERT_NEXT(a_rsp_after_load, ctl.load_rsp, rsp_tvalid)

endmodule

>>> rtl/ldss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ldss_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/ldss_ctrl.sv
// Sequencer for the lazy-deletion sampling set: issues datapath commands.
// Depends on ldss_pkg.
module ldss_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic [ldss_pkg::CMD_W-1:0]   req_tuser,
   input  ldss_pkg::dp_status_type      sts,
   output logic                         req_tready,
   output ldss_pkg::ctrl_cmd_type       ctl
);

   localparam logic [3:0] S_SWEEP  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_FRD    = 4'd2;
   localparam logic [3:0] S_FEX    = 4'd3;
   localparam logic [3:0] S_DRAW   = 4'd4;
   localparam logic [3:0] S_DIV    = 4'd5;
   localparam logic [3:0] S_LRD    = 4'd6;
   localparam logic [3:0] S_LCAP   = 4'd7;
   localparam logic [3:0] S_FRD2   = 4'd8;
   localparam logic [3:0] S_FCAP   = 4'd9;
   localparam logic [3:0] S_DEC    = 4'd10;
   localparam logic [3:0] S_DROP   = 4'd11;
   localparam logic [3:0] S_CMP_RD = 4'd12;
   localparam logic [3:0] S_CLR_RD = 4'd13;
   localparam logic [3:0] S_CLR_WR = 4'd14;
   localparam logic [3:0] S_DONE   = 4'd15;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      ctl        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_SWEEP: begin
            ctl.clr_step = 1'b1;
            if (sts.sweep_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.accept    = 1'b1;
               ctl.idx_clear = 1'b1;
               unique case (req_tuser) inside
                  ldss_pkg::CMD_INSERT, ldss_pkg::CMD_REMOVE,
                  ldss_pkg::CMD_CONTAINS:                     state_in = S_FRD;
                  ldss_pkg::CMD_SIZE:                         state_in = S_DONE;
                  ldss_pkg::CMD_SAMPLE, ldss_pkg::CMD_EXTRACT: state_in = S_DRAW;
                  ldss_pkg::CMD_CLEAR:                        state_in = S_CLR_RD;
                  default:                                    state_in = S_CMP_RD;
               endcase
            end
         end
         S_FRD: begin
            ctl.frd_value = 1'b1;
            state_in      = S_FEX;
         end
         S_FEX: begin
            ctl.exec_single = 1'b1;
            state_in        = S_DONE;
         end
         S_DRAW: begin
            if (sts.empty_set) begin
               ctl.set_empty = 1'b1;
               state_in      = S_DONE;
            end else begin
               ctl.rng_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               ctl.idx_from_rem = 1'b1;
               state_in         = S_LRD;
            end else begin
               ctl.div_step = 1'b1;
            end
         end
         S_LRD: begin
            ctl.lrd_idx = 1'b1;
            state_in    = S_LCAP;
         end
         S_LCAP: begin
            ctl.cap_elem = 1'b1;
            state_in     = (sts.cmd == ldss_pkg::CMD_CLEAR) ? S_CLR_WR : S_FRD2;
         end
         S_FRD2: begin
            ctl.frd_elem = 1'b1;
            state_in     = S_FCAP;
         end
         S_FCAP: begin
            ctl.cap_flag = 1'b1;
            ctl.lrd_last = 1'b1;
            state_in     = S_DEC;
         end
         S_DEC: begin
            ctl.cap_last = 1'b1;
            state_in     = S_DROP;
            if (sts.elem_live) begin
               if (sts.cmd == ldss_pkg::CMD_COMPACT) begin
                  ctl.idx_inc = 1'b1;
                  state_in    = S_CMP_RD;
               end else if (sts.cmd == ldss_pkg::CMD_SAMPLE) begin
                  ctl.set_vout = 1'b1;
                  state_in     = S_DONE;
               end
            end
         end
         S_DROP: begin
            ctl.drop = 1'b1;
            if (sts.cmd == ldss_pkg::CMD_COMPACT) begin
               state_in = S_CMP_RD;
            end else if (sts.elem_live) begin
               ctl.set_vout = 1'b1;
               state_in     = S_DONE;
            end else begin
               state_in = S_DRAW;
            end
         end
         S_CMP_RD: begin
            if (sts.idx_at_end || sts.stale_zero) begin
               ctl.stale_clear = 1'b1;
               state_in        = S_DONE;
            end else begin
               state_in = S_LRD;
            end
         end
         S_CLR_RD: begin
            if (sts.idx_at_end) begin
               ctl.list_clear = 1'b1;
               state_in       = S_DONE;
            end else begin
               state_in = S_LRD;
            end
         end
         S_CLR_WR: begin
            ctl.flag_clear_elem = 1'b1;
            ctl.idx_inc         = 1'b1;
            state_in            = S_CLR_RD;
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               ctl.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register; reset starts the flag clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/ldss_dp.sv
// Datapath: flag and list memories, counters, generator, divider, result.
// Depends on ldss_pkg and ldss_ram.
module ldss_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [ldss_pkg::VALUE_W-1:0]      req_tdata,
   input  logic [ldss_pkg::CMD_W-1:0]        req_tuser,
   input  logic                              csr_wr_en,
   input  logic [ldss_pkg::RNG_W-1:0]        csr_wr_data,
   input  logic                              rsp_tready,
   input  ldss_pkg::ctrl_cmd_type            ctl,
   output ldss_pkg::dp_status_type           sts,
   output logic                              rsp_tvalid,
   output logic [ldss_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [ldss_pkg::RSP_USER_W-1:0]   rsp_tuser
);

   localparam int VW = ldss_pkg::VALUE_W;
   localparam int LW = ldss_pkg::LEN_W;
   localparam int IW = ldss_pkg::IDX_W;
   localparam int RW = ldss_pkg::RNG_W;
   localparam int FW = ldss_pkg::FLAG_W;
   localparam int SW = ldss_pkg::STATUS_W;

   logic [VW-1:0]                  sweep_ff;
   logic [ldss_pkg::CMD_W-1:0]     cmd_ff;
   logic [VW-1:0]                  value_ff;
   logic [LW-1:0]                  len_ff;
   logic [LW-1:0]                  stale_ff;
   logic [RW-1:0]                  rng_ff;
   logic [RW-1:0]                  dvd_ff;
   logic [LW-1:0]                  rem_ff;
   logic [ldss_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic [LW-1:0]                  idx_ff;
   logic [VW-1:0]                  elem_ff;
   logic [VW-1:0]                  last_ff;
   logic                           elem_live_ff;
   logic [SW-1:0]                  status_ff;
   logic                           found_ff;
   logic [VW-1:0]                  vout_ff;
   logic                           rsp_valid_ff;
   logic [ldss_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [ldss_pkg::RSP_USER_W-1:0] rsp_user_ff;

   logic [RW-1:0] rng_in;
   logic [LW:0]   rem_shift;
   logic [LW:0]   rem_sub;
   logic [LW-1:0] len_m1;
   logic [LW-1:0] live_now;

   logic          flag_we;
   logic [VW-1:0] flag_waddr;
   logic [FW-1:0] flag_wdata;
   logic [VW-1:0] flag_raddr;
   logic [FW-1:0] flag_q;
   logic          list_we;
   logic [IW-1:0] list_waddr;
   logic [VW-1:0] list_wdata;
   logic [IW-1:0] list_raddr;
   logic [VW-1:0] list_q;

   // single-value command outcome from the flag just read
   logic          ex_flag_we;
   logic [FW-1:0] ex_flag_val;
   logic          ex_append;
   logic          ex_stale_inc;
   logic          ex_stale_dec;
   logic [SW-1:0] ex_status;
   logic          ex_found;

   assign rng_in    = ldss_pkg::xorshift_next(rng_ff);
   assign len_m1    = len_ff - LW'(1);
   assign live_now  = len_ff - stale_ff;
   assign rem_shift = {rem_ff, dvd_ff[RW-1]};
   assign rem_sub   = rem_shift - {1'b0, len_ff};

   // decode insert, remove and contains
   always_comb begin
      ex_flag_we   = 1'b0;
      ex_flag_val  = ldss_pkg::FLAG_LIVE;
      ex_append    = 1'b0;
      ex_stale_inc = 1'b0;
      ex_stale_dec = 1'b0;
      ex_status    = ldss_pkg::ST_OK;
      ex_found     = 1'b0;
      case (cmd_ff)
         ldss_pkg::CMD_INSERT: begin
            if (flag_q == ldss_pkg::FLAG_LIVE) begin
               ex_status = ldss_pkg::ST_PRESENT;
            end else if (flag_q == ldss_pkg::FLAG_STALE) begin
               ex_flag_we   = 1'b1;
               ex_stale_dec = (stale_ff != '0);
            end else if (len_ff >= LW'(ldss_pkg::LIST_CAPACITY)) begin
               ex_status = ldss_pkg::ST_FULL;
            end else begin
               ex_flag_we = 1'b1;
               ex_append  = 1'b1;
            end
         end
         ldss_pkg::CMD_REMOVE: begin
            if (flag_q == ldss_pkg::FLAG_LIVE) begin
               ex_flag_we   = 1'b1;
               ex_flag_val  = ldss_pkg::FLAG_STALE;
               ex_stale_inc = 1'b1;
            end else begin
               ex_status = ldss_pkg::ST_ABSENT;
            end
         end
         default: begin
            ex_found = (flag_q == ldss_pkg::FLAG_LIVE);
         end
      endcase
   end

   // memory port selection
   always_comb begin
      flag_we    = 1'b0;
      flag_waddr = elem_ff;
      flag_wdata = ldss_pkg::FLAG_ABSENT;
      if (ctl.clr_step) begin
         flag_we    = 1'b1;
         flag_waddr = sweep_ff;
      end else if (ctl.exec_single) begin
         flag_we    = ex_flag_we;
         flag_waddr = value_ff;
         flag_wdata = ex_flag_val;
      end else if (ctl.drop || ctl.flag_clear_elem) begin
         flag_we = 1'b1;
      end
      flag_raddr = ctl.frd_value ? value_ff : elem_ff;

      list_we    = 1'b0;
      list_waddr = idx_ff[IW-1:0];
      list_wdata = last_ff;
      if (ctl.exec_single && ex_append) begin
         list_we    = 1'b1;
         list_waddr = len_ff[IW-1:0];
         list_wdata = value_ff;
      end else if (ctl.drop) begin
         list_we = 1'b1;
      end
      list_raddr = ctl.lrd_last ? len_m1[IW-1:0] : idx_ff[IW-1:0];
   end

   ldss_ram #(.WIDTH(FW), .DEPTH(ldss_pkg::VALUE_SPACE)) u_flags (
      .clock (clock),
      .we    (flag_we),
      .waddr (flag_waddr),
      .wdata (flag_wdata),
      .raddr (flag_raddr),
      .rdata (flag_q)
   );

   ldss_ram #(.WIDTH(VW), .DEPTH(ldss_pkg::LIST_CAPACITY)) u_list (
      .clock (clock),
      .we    (list_we),
      .waddr (list_waddr),
      .wdata (list_wdata),
      .raddr (list_raddr),
      .rdata (list_q)
   );

   // control registers: sweep, counts, generator, response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= '0;
         len_ff       <= '0;
         stale_ff     <= '0;
         rng_ff       <= ldss_pkg::RNG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctl.clr_step) begin
            sweep_ff <= sweep_ff + VW'(1);
         end
         if (csr_wr_en && (csr_wr_data != '0)) begin
            rng_ff <= csr_wr_data;
         end else if (ctl.rng_start) begin
            rng_ff <= rng_in;
         end
         if (ctl.exec_single) begin
            if (ex_append) begin
               len_ff <= len_ff + LW'(1);
            end
            if (ex_stale_inc) begin
               stale_ff <= stale_ff + LW'(1);
            end else if (ex_stale_dec) begin
               stale_ff <= stale_ff - LW'(1);
            end
         end
         if (ctl.drop) begin
            len_ff <= len_m1;
            if (!elem_live_ff && (stale_ff != '0)) begin
               stale_ff <= stale_ff - LW'(1);
            end
         end
         if (ctl.list_clear) begin
            len_ff   <= '0;
            stale_ff <= '0;
         end
         if (ctl.stale_clear) begin
            stale_ff <= '0;
         end
         if (ctl.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         cmd_ff    <= req_tuser;
         value_ff  <= req_tdata;
         status_ff <= ldss_pkg::ST_OK;
         found_ff  <= 1'b0;
         vout_ff   <= '0;
      end
      if (ctl.exec_single) begin
         status_ff <= ex_status;
         found_ff  <= ex_found;
      end
      if (ctl.set_empty) begin
         status_ff <= ldss_pkg::ST_EMPTY;
      end
      if (ctl.set_vout) begin
         vout_ff <= elem_ff;
      end
      // one restoring division step per cycle
      if (ctl.rng_start) begin
         dvd_ff     <= rng_in;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (ctl.div_step) begin
         dvd_ff     <= dvd_ff << 1;
         rem_ff     <= rem_sub[LW] ? rem_shift[LW-1:0] : rem_sub[LW-1:0];
         div_cnt_ff <= div_cnt_ff + ldss_pkg::DIV_CNT_W'(1);
      end
      if (ctl.idx_clear) begin
         idx_ff <= '0;
      end else if (ctl.idx_from_rem) begin
         idx_ff <= rem_ff;
      end else if (ctl.idx_inc) begin
         idx_ff <= idx_ff + LW'(1);
      end
      if (ctl.cap_elem) begin
         elem_ff <= list_q;
      end
      if (ctl.cap_flag) begin
         elem_live_ff <= (flag_q == ldss_pkg::FLAG_LIVE);
      end
      if (ctl.cap_last) begin
         last_ff <= list_q;
      end
      if (ctl.load_rsp) begin
         rsp_data_ff <= {(ldss_pkg::RSP_DATA_W - LW - VW)'(0), live_now, vout_ff};
         rsp_user_ff <= {found_ff, status_ff};
      end
   end

   // status back to the sequencer
   always_comb begin
      sts.cmd        = cmd_ff;
      sts.sweep_done = &sweep_ff;
      sts.empty_set  = (len_ff <= stale_ff);
      sts.div_done   = (div_cnt_ff == ldss_pkg::DIV_CNT_W'(RW));
      sts.idx_at_end = (idx_ff >= len_ff);
      sts.stale_zero = (stale_ff == '0);
      sts.stale_ok   = (stale_ff <= len_ff);
      sts.elem_live  = elem_live_ff;
      sts.rsp_free   = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
